// ===== rtl/core/binary_erode_open_check_macros.svh =====
// Assertion macros for the binary erode/open check block.
`ifndef BINARY_ERODE_OPEN_CHECK_MACROS_SVH
`define BINARY_ERODE_OPEN_CHECK_MACROS_SVH
`ifndef SYNTHESIS
`define BOC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("boc assertion failed");
`define BOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("boc assertion failed");
`else
`define BOC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BOC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/boc_pkg.sv =====
// Shared types and constants of the binary erode/open check block.
package boc_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RESET_DIM      = 1024;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int TDATA_W        = 8;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // Classification of one beat, as the back end needs it.
    // Position flags refer to the eroded pixel p = t-W-1 that the beat completes.
    typedef struct packed {
        logic pix;    // pixel written to the line store
        logic emit;   // beat completes an eroded pixel
        logic last;   // final eroded pixel of the frame
        logic top;    // row of p is 0
        logic bot;    // row of p is H-1
        logic rlt2;   // row of p below 2
        logic left;   // column of p is 0
        logic right;  // column of p is W-1
        logic clt2;   // column of p below 2
    } t_item_flags;

    localparam int FLAGS_W = $bits(t_item_flags);

endpackage

// ===== rtl/core/boc_ram.sv =====
// Generic single-write, single-read RAM with registered read-first output.
module boc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/boc_queue.sv =====
// Short FIFO between the classifying front end and the window back end.
module boc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [AW:0]      r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

endmodule

// ===== rtl/core/boc_front.sv =====
// Front end: frame position counters, configuration and beat classification.
module boc_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [boc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [boc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    input  logic                          i_mode,
    input  logic                          i_pixel,
    input  logic                          i_full,
    output logic                          o_ready,
    output logic                          o_push,
    output boc_pkg::t_item_flags          o_flags,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_ct,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_pc
);

    import boc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
        if (v == '0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    logic [WW-1:0] r_w, n_w;
    logic [HW-1:0] r_h, n_h;
    logic [CW-1:0] r_ct, n_ct;
    logic [RW-1:0] r_rt, n_rt;

    logic [WW-1:0] wm1;
    logic [RW-1:0] h_ext;
    logic          ct_zero;
    logic          last_col;
    logic          frame_end;
    logic [RW-1:0] row_p;
    logic [CW-1:0] col_p;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        wm1       = r_w - WW'(1);
        h_ext     = RW'(r_h);
        ct_zero   = (r_ct == '0);
        last_col  = (WW'(r_ct) == wm1);
        frame_end = (r_rt == h_ext + RW'(1));
        // eroded pixel lags the input by one row and one column
        row_p     = ct_zero ? r_rt - RW'(2) : r_rt - RW'(1);
        col_p     = ct_zero ? CW'(wm1) : r_ct - CW'(1);

        o_flags.pix   = i_pixel && !i_mode && (r_rt < h_ext);
        o_flags.emit  = (r_rt != '0) && !((r_rt == RW'(1)) && ct_zero);
        o_flags.last  = frame_end;
        o_flags.top   = (row_p == '0);
        o_flags.bot   = (row_p == h_ext - RW'(1));
        o_flags.rlt2  = (row_p < RW'(2));
        o_flags.left  = (col_p == '0);
        o_flags.right = ct_zero;
        o_flags.clt2  = (col_p < CW'(2));
        o_ct          = r_ct;
        o_pc          = col_p;
    end

    always_comb begin
        n_w  = r_w;
        n_h  = r_h;
        n_ct = r_ct;
        n_rt = r_rt;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_IMAGE_WIDTH: begin
                    n_w = WW'(clamp_dim(i_cfg_data, MAX_WIDTH));
                end
                REG_IMAGE_HEIGHT: begin
                    n_h = HW'(clamp_dim(i_cfg_data, MAX_HEIGHT));
                end
                default: begin
                end
            endcase
            n_ct = '0;
            n_rt = '0;
        end else if (o_push) begin
            if (frame_end) begin
                n_ct = '0;
                n_rt = '0;
            end else if (last_col) begin
                n_ct = '0;
                n_rt = r_rt + RW'(1);
            end else begin
                n_ct = r_ct + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w  <= WW'(clamp_dim(CFG_W'(RESET_DIM), MAX_WIDTH));
            r_h  <= HW'(clamp_dim(CFG_W'(RESET_DIM), MAX_HEIGHT));
            r_ct <= '0;
            r_rt <= '0;
        end else begin
            r_w  <= n_w;
            r_h  <= n_h;
            r_ct <= n_ct;
            r_rt <= n_rt;
        end
    end

endmodule

// ===== rtl/core/boc_back.sv =====
// Back end: line stores, pixel and eroded windows, erosion and opening check.
module boc_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_q_valid,
    input  boc_pkg::t_item_flags         i_flags,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_ct,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_pc,
    output logic                         o_pop,
    input  logic                         i_tready,
    output logic                         o_tvalid,
    output logic                         o_eroded,
    output logic                         o_last,
    output logic                         o_ok,
    output logic                         o_match
);

    import boc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    function automatic logic all_set(input logic [2:0] col, input logic [2:0] m);
        return &(col | ~m);
    endfunction

    function automatic logic any_set(input logic [2:0] col, input logic [2:0] m);
        return |(col & m);
    endfunction

    logic adv;

    // stage A: pixel line store read
    logic        r_a_v;
    t_item_flags r_a_f;
    logic [CW-1:0] r_a_ct, r_a_pc;
    logic [1:0]  prd_ram, prd;
    logic        r_pfwd;
    logic [1:0]  r_pfwd_d;

    // stage B: pixel window, erosion, eroded line store read
    logic        r_b_v;
    t_item_flags r_b_f;
    logic [CW-1:0] r_b_pc;
    logic [2:0]  r_pw0, r_pw1, r_pw2;   // bit2 row R-1, bit1 row R, bit0 row R+1
    logic [2:0]  pmask;
    logic        ero;
    logic [1:0]  erd_ram, erd;
    logic        r_efwd;
    logic [1:0]  r_efwd_d;

    // stage C: eroded window and dilation compare
    logic        r_c_v;
    t_item_flags r_c_f;
    logic        r_c_e;
    logic [3:0]  r_c_pq;
    logic [2:0]  r_ew0, r_ew1, r_ew2;   // bit2 row R-2, bit1 row R-1, bit0 row R
    logic [2:0]  m3, m2;
    logic        dil0, dil1, dil2, dil3;
    logic        ok_here;

    logic r_o_v, r_o_e, r_o_last, r_o_ok;
    logic r_match;

    assign adv   = !r_o_v || i_tready;
    assign o_pop = adv && i_q_valid;

    assign prd = r_pfwd ? r_pfwd_d : prd_ram;
    assign erd = r_efwd ? r_efwd_d : erd_ram;

    boc_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_pix_line (
        .i_clk  (i_clk),
        .i_we   (adv && r_a_v),
        .i_waddr(r_a_ct),
        .i_wdata({prd[0], r_a_f.pix}),
        .i_re   (adv),
        .i_raddr(i_ct),
        .o_rdata(prd_ram)
    );

    boc_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_ero_line (
        .i_clk  (i_clk),
        .i_we   (adv && r_b_v && r_b_f.emit),
        .i_waddr(r_b_pc),
        .i_wdata({erd[0], ero}),
        .i_re   (adv),
        .i_raddr(r_a_pc),
        .o_rdata(erd_ram)
    );

    // border neighbours count as set
    always_comb begin
        pmask = {!r_b_f.top, 1'b1, !r_b_f.bot};
        ero   = (all_set(r_pw0, pmask) || r_b_f.left) && all_set(r_pw1, pmask) &&
                (all_set(r_pw2, pmask) || r_b_f.right);
    end

    // Each input pixel is compared once, when its last possible covering
    // eroded pixel is known; bottom row and right column finish early.
    always_comb begin
        m3   = {!r_c_f.rlt2, !r_c_f.top, 1'b1};
        m2   = {1'b0, !r_c_f.top, 1'b1};
        dil0 = (any_set(r_ew0, m3) && !r_c_f.clt2) || (any_set(r_ew1, m3) && !r_c_f.left) ||
               any_set(r_ew2, m3);
        dil1 = (any_set(r_ew1, m3) && !r_c_f.left) || any_set(r_ew2, m3);
        dil2 = (any_set(r_ew0, m2) && !r_c_f.clt2) || (any_set(r_ew1, m2) && !r_c_f.left) ||
               any_set(r_ew2, m2);
        dil3 = (any_set(r_ew1, m2) && !r_c_f.left) || any_set(r_ew2, m2);
        ok_here = (!(!r_c_f.top && !r_c_f.left) || (dil0 == r_c_pq[3])) &&
                  (!(r_c_f.right && !r_c_f.top)  || (dil1 == r_c_pq[2])) &&
                  (!(r_c_f.bot && !r_c_f.left)   || (dil2 == r_c_pq[1])) &&
                  (!(r_c_f.bot && r_c_f.right)   || (dil3 == r_c_pq[0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_o_v   <= 1'b0;
            r_pfwd  <= 1'b0;
            r_efwd  <= 1'b0;
            r_match <= 1'b1;
        end else begin
            if (adv) begin
                r_a_v  <= i_q_valid;
                r_b_v  <= r_a_v;
                r_c_v  <= r_b_v && r_b_f.emit;
                r_o_v  <= r_c_v;
                // back-to-back beats on one column (single-pixel rows)
                r_pfwd <= r_a_v && i_q_valid && (i_ct == r_a_ct);
                r_efwd <= r_b_v && r_b_f.emit && r_a_v && r_a_f.emit && (r_a_pc == r_b_pc);
            end
            if (i_cfg_we) begin
                r_match <= 1'b1;
            end else if (adv && r_c_v) begin
                r_match <= r_c_f.last ? 1'b1 : (r_match && ok_here);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_f    <= i_flags;
            r_a_ct   <= i_ct;
            r_a_pc   <= i_pc;
            r_pfwd_d <= {prd[0], r_a_f.pix};
            r_b_f    <= r_a_f;
            r_b_pc   <= r_a_pc;
            r_efwd_d <= {erd[0], ero};
            r_c_f    <= r_b_f;
            r_o_e    <= r_c_e;
            r_o_last <= r_c_f.last;
            r_o_ok   <= r_c_f.last && r_match && ok_here;
            if (r_a_v) begin
                r_pw0 <= r_pw1;
                r_pw1 <= r_pw2;
                r_pw2 <= {prd[1], prd[0], r_a_f.pix};
            end
            if (r_b_v && r_b_f.emit) begin
                r_ew0  <= r_ew1;
                r_ew1  <= r_ew2;
                r_ew2  <= {erd[1], erd[0], ero};
                r_c_e  <= ero;
                r_c_pq <= {r_pw0[2], r_pw1[2], r_pw0[1], r_pw1[1]};
            end
        end
    end

    assign o_tvalid = r_o_v;
    assign o_eroded = r_o_e;
    assign o_last   = r_o_last;
    assign o_ok     = r_o_ok;
    assign o_match  = r_match;

endmodule

// ===== rtl/core/binary_erode_open_check.sv =====
// Top level: 3x3 binary opening with erosion output and a frame check.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-------------------------------------
//  s_axis   | s_axis_tvalid / s_axis_tready   | tdata[0] pixel, tuser mode
//  m_axis   | m_axis_tvalid / m_axis_tready   | tdata[0] eroded_pixel, tdata[1]
//           |                                 | frame_ok, tlast last_of_frame
//  cfg      | i_cfg_we                        | i_cfg_idx, i_cfg_data
//
// One beat per cycle in and out unless the queue fills or m_axis stalls; an eroded pixel
// leaves W+1 input beats after its own pixel, through the queue and the three window stages.
// Two line stores of MAX_WIDTH x 2 bits hold the pixel and eroded rows; borders
// are handled by position, so reset needs no clearing pass.
// An output stall freezes the back stages; the four-entry queue keeps s_axis open until it fills.
module binary_erode_open_check #(
    parameter int MAX_WIDTH  = boc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = boc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [boc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [boc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [boc_pkg::TDATA_W-1:0]   s_axis_tdata,  // [0] pixel
    input  logic                          s_axis_tuser,  // [0] mode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [boc_pkg::TDATA_W-1:0]   m_axis_tdata,  // [0] eroded_pixel, [1] frame_ok
    output logic                          m_axis_tlast
);

    import boc_pkg::*;

    `include "binary_erode_open_check_macros.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = FLAGS_W + 2 * CW;

    logic          push, pop, q_full, q_valid;
    t_item_flags   f_flags, q_flags;
    logic [CW-1:0] f_ct, f_pc, q_ct, q_pc;
    logic [QW-1:0] q_out;
    logic          eroded, ok, match;

    boc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid   (s_axis_tvalid),
        .i_mode    (s_axis_tuser),
        .i_pixel   (s_axis_tdata[0]),
        .i_full    (q_full),
        .o_ready   (s_axis_tready),
        .o_push    (push),
        .o_flags   (f_flags),
        .o_ct      (f_ct),
        .o_pc      (f_pc)
    );

    boc_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_flags, f_ct, f_pc}),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_out)
    );

    assign q_flags = q_out[QW-1 -: FLAGS_W];
    assign q_ct    = q_out[2*CW-1 -: CW];
    assign q_pc    = q_out[CW-1:0];

    boc_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (i_cfg_we),
        .i_q_valid(q_valid),
        .i_flags  (q_flags),
        .i_ct     (q_ct),
        .i_pc     (q_pc),
        .o_pop    (pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_eroded (eroded),
        .o_last   (m_axis_tlast),
        .o_ok     (ok),
        .o_match  (match)
    );

    assign m_axis_tdata = {(TDATA_W - 2)'(0), ok, eroded};

    // verdict only rides on the closing beat of a frame
    `BOC_ASSERT_SAME(a_ok_only_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1],
        m_axis_tlast)
    // the running verdict is already restarted while the closing beat is on m_axis
    `BOC_ASSERT_SAME(a_match_rearmed, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, match)
    `BOC_ASSERT_NEXT(a_cfg_rearms, i_clk, i_rst_n, i_cfg_we, match)

endmodule

// ===== dv/binary_erode_open_check_test.sv =====
// Self-checking testbench for the 3x3 binary opening block with frame verdict.
module binary_erode_open_check_test;
    import boc_pkg::*;

    localparam int MAXW      = DEF_MAX_WIDTH;
    localparam int MAXH      = DEF_MAX_HEIGHT;
    localparam int IDLE_WAIT = 20;
    localparam int WDOG_MAX  = 5000;
    localparam int LONG_HOLD = 600;

    typedef struct {
        bit mode;
        bit pix;
    } pix_beat_t;

    typedef struct {
        bit ero;
        bit last;
        bit ok;
    } ero_beat_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    logic               s_axis_tuser = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;

    binary_erode_open_check DUT (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    bit  px_mem [MAXW*MAXH];
    bit  er_mem [MAXW*MAXH];
    int  img_w = 1024, img_h = 1024;
    int  pos_cnt = 0;
    bit  verdict = 1'b1;

    pix_beat_t pend_q[$];
    ero_beat_t ero_q[$];

    bit  in_taken = 1'b0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;
    int  tx_gap = 0, rx_gap = 0, hold_cnt = 0;
    int  err_cnt = 0, wdog = 0, sent = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clamp_dim(int v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic bit erode_px(int p);
        int r, c, rr, cc;
        r = p / img_w;
        c = p % img_w;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                if (rr < 0 || cc < 0 || rr >= img_h || cc >= img_w) continue;
                if (!px_mem[rr*img_w + cc]) return 1'b0;
            end
        return 1'b1;
    endfunction

    function automatic bit opening_holds();
        int rr, cc;
        bit d;
        for (int r = 0; r < img_h; r++)
            for (int c = 0; c < img_w; c++) begin
                d = 1'b0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if (rr < 0 || cc < 0 || rr >= img_h || cc >= img_w) continue;
                        if (er_mem[rr*img_w + cc]) d = 1'b1;
                    end
                if (d != px_mem[r*img_w + c]) return 1'b0;
            end
        return 1'b1;
    endfunction

    function automatic void predict_erosion(bit mode, bit pin);
        int n, t, p;
        bit v;
        ero_beat_t e;
        n = img_w * img_h;
        t = pos_cnt;
        v = pin & ~mode;
        if (t < n) px_mem[t] = v;
        if (t >= img_w + 1 && t - img_w - 1 < n) begin
            p = t - img_w - 1;
            e.ero = erode_px(p);
            e.last = (p == n - 1);
            er_mem[p] = e.ero;
            if (e.last) verdict = opening_holds();
            e.ok = e.last ? verdict : 1'b0;
            ero_q.push_back(e);
        end
        t++;
        if (t >= n + img_w + 1) begin
            t = 0;
            verdict = 1'b1;
        end
        pos_cnt = t;
    endfunction

    // sender
    always @(negedge i_clk) begin
        pix_beat_t b;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
        end else if (tx_gap > 0) begin
            s_axis_tvalid <= 1'b0;
            tx_gap--;
        end else if (pend_q.size() == 0) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            b = pend_q.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {{(TDATA_W-1){1'b0}}, b.pix};
            s_axis_tuser <= b.mode;
            tx_gap = idle_on ? pick_gap() : 0;
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            m_axis_tready <= 1'b0;
            hold_cnt--;
        end else if (hold_req) begin
            m_axis_tready <= 1'b0;
            hold_cnt = LONG_HOLD;
            hold_req = 1'b0;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap--;
        end else begin
            m_axis_tready <= i_rst_n;
            rx_gap = idle_on ? pick_gap() : 0;
        end
    end

    // monitor: config mirror, input prediction, output check, watchdog
    always @(posedge i_clk) begin
        ero_beat_t e;
        bit out_taken;
        if (i_rst_n) begin
            in_taken = s_axis_tvalid && s_axis_tready;
            out_taken = m_axis_tvalid && m_axis_tready;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_IMAGE_WIDTH) img_w = clamp_dim(i_cfg_data, MAXW);
                else img_h = clamp_dim(i_cfg_data, MAXH);
                pos_cnt = 0;
                verdict = 1'b1;
            end
            if (in_taken) predict_erosion(s_axis_tuser, s_axis_tdata[0]);
            if (out_taken) begin
                if (ero_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("unexpected beat: pix %0b last %0b ok %0b",
                        m_axis_tdata[0], m_axis_tlast, m_axis_tdata[1]);
                end else begin
                    e = ero_q.pop_front();
                    if (m_axis_tdata[0] !== e.ero || m_axis_tlast !== e.last ||
                        m_axis_tdata[1] !== e.ok) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: exp pix %0b last %0b ok %0b, got %0b %0b %0b",
                                e.ero, e.last, e.ok,
                                m_axis_tdata[0], m_axis_tlast, m_axis_tdata[1]);
                    end
                end
            end
            wdog = (in_taken || out_taken) ? 0 : wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("binary_erode_open_check test failed");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (pend_q.size() != 0 || s_axis_tvalid || ero_q.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, int v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // kind: 0 random, 1 rectangles, 2 rectangles with noise, 3 solid, 4 empty,
    // 5 stray drains in the pixels and stray pixels in the drain tail
    task automatic queue_frame(int w, int h, int kind, int cut);
        bit img [];
        pix_beat_t b;
        int n, x0, y0, rw, rh, dens;
        n = w * h;
        img = new[n];
        dens = $urandom_range(10, 95);
        for (int i = 0; i < n; i++)
            case (kind)
                0: img[i] = ($urandom_range(0, 99) < dens);
                3: img[i] = 1'b1;
                default: img[i] = 1'b0;
            endcase
        if (kind == 1 || kind == 2) begin
            repeat ($urandom_range(1, 3)) begin
                rw = (w < 3) ? w : $urandom_range(3, w);
                rh = (h < 3) ? h : $urandom_range(3, h);
                x0 = $urandom_range(0, w - rw);
                y0 = $urandom_range(0, h - rh);
                for (int y = y0; y < y0 + rh; y++)
                    for (int x = x0; x < x0 + rw; x++) img[y*w + x] = 1'b1;
            end
            if (kind == 2) img[$urandom_range(0, n - 1)] ^= 1'b1;
        end
        for (int i = 0; i < n + w + 1 - cut; i++) begin
            if (i < n) begin
                b.mode = (kind == 5) && ($urandom_range(0, 9) == 0);
                b.pix = b.mode ? 1'($urandom) : img[i];
            end else begin
                b.mode = !((kind == 5) && ($urandom_range(0, 3) == 0));
                b.pix = 1'($urandom);
            end
            pend_q.push_back(b);
            sent++;
        end
    endtask

    initial begin
        int w, h, k;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        write_reg(REG_IMAGE_WIDTH, 5);
        write_reg(REG_IMAGE_HEIGHT, 4);
        queue_frame(5, 4, 3, 0);
        queue_frame(5, 4, 4, 0);
        pend_q.push_back('{1'b0, 1'b1});            // lone set pixel
        sent++;
        queue_frame(5, 4, 5, 1);
        write_reg(REG_IMAGE_WIDTH, 0);              // taken as one
        write_reg(REG_IMAGE_HEIGHT, 0);
        queue_frame(1, 1, 3, 0);
        queue_frame(1, 1, 5, 0);
        write_reg(REG_IMAGE_WIDTH, 2047);           // clipped to the maximum
        write_reg(REG_IMAGE_HEIGHT, 1);
        queue_frame(MAXW, 1, 0, 0);
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 2047);
        queue_frame(1, MAXH, 1, 0);
        write_reg(REG_IMAGE_WIDTH, 1024);
        write_reg(REG_IMAGE_HEIGHT, 2);
        queue_frame(MAXW, 2, 3, 0);
        sent = 0;

        // random frames; receiver stalls hard during the first one
        hold_req = 1'b1;
        while (sent < 1500) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            write_reg(REG_IMAGE_WIDTH, w);
            write_reg(REG_IMAGE_HEIGHT, h);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) begin
                k = $urandom_range(0, 9);
                k = (k < 3) ? 1 : (k < 5) ? 0 : (k < 6) ? 2 : (k < 7) ? 3 :
                    (k < 8) ? 4 : 5;
                queue_frame(w, h, k, 0);
                if ($urandom_range(0, 2) == 0) wait_idle();
            end
            if ($urandom_range(0, 5) == 0) queue_frame(w, h, 0, $urandom_range(1, w * h));
        end
        idle_on = 1'b1;

        wait_idle();
        if (err_cnt == 0 && ero_q.size() == 0) begin
            $display("binary_erode_open_check test passed");
        end else begin
            $display("binary_erode_open_check test failed");
        end
        $finish;
    end

endmodule
